FILE: src/lgg_pkg.sv
// Shared types and constants for the life grid generation block.
package lgg_pkg;

  localparam int unsigned GRID_SIZE = 32;
  localparam int unsigned ROW_IDX_W = $clog2(GRID_SIZE);
  localparam int unsigned CNT_W     = $clog2(GRID_SIZE + 1);
  localparam int unsigned IDX_FLD_W = 5;
  localparam int unsigned BITS_FLD_W = 32;

  typedef logic [GRID_SIZE-1:0] row_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [IDX_FLD_W-1:0]  row_index;
    logic [BITS_FLD_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [IDX_FLD_W-1:0]  out_row_index;
    logic [BITS_FLD_W-1:0] out_row_bits;
    logic                  last_row;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: src/lgg_rule.sv
// Next-generation row from three adjacent rows under rule B3/S23.
module lgg_rule (
  input  lgg_pkg::row_t above_i,
  input  lgg_pkg::row_t mid_i,
  input  lgg_pkg::row_t below_i,
  output lgg_pkg::row_t next_o
);

  logic [lgg_pkg::GRID_SIZE+1:0] above_pad;
  logic [lgg_pkg::GRID_SIZE+1:0] mid_pad;
  logic [lgg_pkg::GRID_SIZE+1:0] below_pad;

  // Pad with dead cells so the edges do not wrap.
  assign above_pad = {1'b0, above_i, 1'b0};
  assign mid_pad   = {1'b0, mid_i, 1'b0};
  assign below_pad = {1'b0, below_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int p = 0; p < lgg_pkg::GRID_SIZE; p++) begin
      n = 4'(above_pad[p]) + 4'(above_pad[p+1]) + 4'(above_pad[p+2])
        + 4'(mid_pad[p]) + 4'(mid_pad[p+2])
        + 4'(below_pad[p]) + 4'(below_pad[p+1]) + 4'(below_pad[p+2]);
      next_o[p] = (n == 4'd3) || (mid_i[p] && (n == 4'd2));
    end
  end

endmodule

FILE: src/lgg_row_cell.sv
// One grid row held in a link of the row chain.
module lgg_row_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lgg_pkg::cell_ctrl_t ctrl_i,
  input  lgg_pkg::row_t      shift_in_i,
  input  lgg_pkg::row_t      load_row_i,
  output lgg_pkg::row_t      row_o
);

  lgg_pkg::row_t row_q;
  lgg_pkg::row_t row_d;

  always_comb begin
    priority if (ctrl_i.shift) begin
      row_d = shift_in_i;
    end else if (ctrl_i.load) begin
      row_d = load_row_i;
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

FILE: src/life_grid_generation.sv
// Top level of the bounded-grid life generation block.
//
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-----------------------
// command | in        | start high, busy low     | item_i (in_item_t)
// result  | out       | res_valid_o strobe       | res_o (out_item_t)
//
// A load beat writes one row in the accept cycle; busy stays low, so
// loads may come back to back. A step beat raises busy while the row
// chain rotates once per cycle; each head row reaches res_o through a
// register in the cycle after, and a final flush state pushes the last
// row through the rule window. The rule window (rows r-1, r, r+1 around
// the head) sets the cost: one row per cycle during a step.
// Reset clears every cell and drops busy. The receiver cannot stall:
// res_valid_o marks each result for a single cycle.
module life_grid_generation (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lgg_pkg::in_item_t item_i,
  output logic              res_valid_o,
  output lgg_pkg::out_item_t res_o
);

  localparam int unsigned G = lgg_pkg::GRID_SIZE;

  logic                      busy_q, busy_d;
  logic [lgg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      accept;
  logic                      flush;

  lgg_pkg::row_t             rows [G];
  lgg_pkg::row_t             head;
  lgg_pkg::row_t             below;
  lgg_pkg::row_t             next_row;
  lgg_pkg::row_t             load_row;
  lgg_pkg::row_t             prev_q, cur_q;
  lgg_pkg::cell_ctrl_t       ctrl [G];

  logic                      res_valid_q;
  lgg_pkg::out_item_t        res_q;

  assign accept = start && !busy_q;
  assign flush  = (cnt_q == lgg_pkg::CNT_W'(G));
  assign head   = rows[0];
  assign load_row = item_i.row_bits[G-1:0];

  // Per-row control: shift the whole chain while stepping, else load the
  // addressed row. Indices beyond the grid match no cell and drop.
  always_comb begin
    for (int i = 0; i < G; i++) begin
      ctrl[i].shift = busy_q;
      ctrl[i].load  = accept && (item_i.op == lgg_pkg::OP_LOAD) &&
                      (item_i.row_index == lgg_pkg::IDX_FLD_W'(i));
    end
  end

  // Row chain: row 0 at the head, new rows enter at the tail.
  for (genvar i = 0; i < G; i++) begin : g_row
    lgg_pkg::row_t shift_in;
    if (i == G - 1) begin : g_tail
      assign shift_in = next_row;
    end else begin : g_link
      assign shift_in = rows[i+1];
    end
    lgg_row_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[i]),
      .shift_in_i (shift_in),
      .load_row_i (load_row),
      .row_o      (rows[i])
    );
  end

  // Window over rows r-1 (prev_q), r (cur_q) and r+1 (head). Past the
  // last row, the row below is dead.
  assign below = flush ? '0 : head;

  lgg_rule u_rule (
    .above_i (prev_q),
    .mid_i   (cur_q),
    .below_i (below),
    .next_o  (next_row)
  );

  // Advance the window; the first cycle of a step seeds the dead row above.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prev_q <= (cnt_q == '0) ? '0 : cur_q;
      cur_q  <= head;
    end
  end

  // Step sequencing.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (flush) begin
        busy_d = 1'b0;
      end
    end else if (accept && (item_i.op == lgg_pkg::OP_STEP)) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      res_valid_q <= busy_q && !flush;
    end
  end

  // Emit the head row before it is replaced.
  always_ff @(posedge clk_i) begin
    if (busy_q && !flush) begin
      res_q.out_row_index <= lgg_pkg::IDX_FLD_W'(cnt_q[lgg_pkg::ROW_IDX_W-1:0]);
      res_q.out_row_bits  <= lgg_pkg::BITS_FLD_W'(head);
      res_q.last_row      <= (cnt_q == lgg_pkg::CNT_W'(G - 1));
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result beat outside a step");

  a_last_ends_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_row) |=> !busy)
    else $error("step did not end after the last row");

  a_rows_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_row) |=> res_valid_o)
    else $error("gap in emitted rows");

  a_step_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.op == lgg_pkg::OP_STEP)) |=> (busy && (cnt_q == '0)))
    else $error("step beat did not start the sequence");

endmodule
